/* src/sorted_priority_queue_defines.svh */
// Assertion helpers for the sorted priority queue.
// Both expect clk and rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq check failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq check failed");

`endif

/* src/spq_pkg.sv */
`default_nettype none
package spq_pkg;

  localparam int DEPTH     = 32;
  localparam int PRIO_BITS = 8;
  localparam int TAG_BITS  = 32;
  localparam int LEN_BITS  = 5;
  localparam int ARR_BITS  = 16;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  typedef logic [PRIO_BITS-1:0] prio_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    prio_t                prio;
    logic [TAG_BITS-1:0]  tag;
    logic [LEN_BITS-1:0]  len;
    logic [ARR_BITS-1:0]  arr;
  } entry_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } ctrl_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage
`default_nettype wire

/* src/spq_cell.sv */
`default_nettype none
module spq_cell (
  input  wire logic            clk,
  input  wire spq_pkg::ctrl_t  ctrl,
  input  wire logic            occ,
  input  wire logic            gt_left,
  input  wire spq_pkg::entry_t left_entry,
  input  wire spq_pkg::entry_t right_entry,
  output logic                 gt,
  output spq_pkg::entry_t      entry_q
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // Empty cells count as "greater", so the boundary is the insert point.
  assign gt = !occ || (entry_r.prio > ctrl.new_entry.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (gt && !gt_left) begin
        entry_nxt = ctrl.new_entry;
      end else if (gt) begin
        entry_nxt = left_entry;
      end
    end else if (ctrl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule
`default_nettype wire

/* src/sorted_priority_queue.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall   | req_type, priority_req, job_tag, desc_length
// out     | output    | out_valid / out_stall | status, priority, tag, length, arrival
//
// One beat per cycle while in_stall is low: every cell of the chain shifts or loads in the accept cycle,
// so the result is registered and appears on the outputs in the cycle after the input beat.
// The output register holds one result; in_stall rises only while it is full
// and out_stall is high.
// Synchronous reset clears the entry count, the arrival counter and out_valid;
// cell contents are left as they are and only occupied cells are ever read.
`default_nettype none
`include "sorted_priority_queue_defines.svh"
module sorted_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_req_type,
  input  wire logic [7:0]  in_priority_req,
  input  wire logic [31:0] in_job_tag,
  input  wire logic [4:0]  in_desc_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [7:0]       out_priority,
  output logic [31:0]      out_tag,
  output logic [4:0]       out_length,
  output logic [15:0]      out_arrival
);
  import spq_pkg::*;

  cnt_t                count_r, count_nxt;
  logic [ARR_BITS-1:0] arr_r, arr_nxt;

  logic                out_valid_r;
  status_t             out_status_r, status_nxt;
  entry_t              out_entry_r, out_entry_nxt;

  logic   in_acc;
  logic   is_rem;
  logic   full;
  logic   empty;
  logic   ins_ok;
  logic   rem_ok;
  ctrl_t  ctrl;

  entry_t cell_q [DEPTH];
  logic   cell_gt [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign is_rem   = (req_t'(in_req_type) == REQ_REMOVE);
  assign full     = (count_r == cnt_t'(DEPTH));
  assign empty    = (count_r == '0);
  assign ins_ok   = in_acc && !is_rem && !full;
  assign rem_ok   = in_acc && is_rem && !empty;

  always_comb begin
    ctrl.ins            = ins_ok;
    ctrl.rem            = rem_ok;
    ctrl.new_entry.prio = prio_t'(in_priority_req);
    ctrl.new_entry.tag  = in_job_tag;
    ctrl.new_entry.len  = in_desc_length;
    ctrl.new_entry.arr  = arr_r;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_gt;
    entry_t left_e;
    entry_t right_e;

    if (i == 0) begin : g_head
      assign left_gt = 1'b0;
      assign left_e  = ctrl.new_entry;
    end else begin : g_body
      assign left_gt = cell_gt[i-1];
      assign left_e  = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = cell_q[i];
    end else begin : g_mid
      assign right_e = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occ         (count_r > cnt_t'(i)),
      .gt_left     (left_gt),
      .left_entry  (left_e),
      .right_entry (right_e),
      .gt          (cell_gt[i]),
      .entry_q     (cell_q[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    arr_nxt       = arr_r;
    status_nxt    = ST_OK;
    out_entry_nxt = '0;
    if (ins_ok) begin
      count_nxt = count_r + 1'b1;
      arr_nxt   = arr_r + 1'b1;
    end else if (rem_ok) begin
      count_nxt     = count_r - 1'b1;
      out_entry_nxt = cell_q[0];
    end else if (in_acc) begin
      status_nxt = is_rem ? ST_EMPTY : ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      arr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      arr_r   <= arr_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r <= status_nxt;
      out_entry_r  <= out_entry_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_priority = 8'(out_entry_r.prio);
  assign out_tag      = out_entry_r.tag;
  assign out_length   = out_entry_r.len;
  assign out_arrival  = out_entry_r.arr;

  `SPQ_ASSERT_NOW(a_count_range, 1'b1, count_r <= cnt_t'(DEPTH))
  `SPQ_ASSERT_NEXT(a_ins_count, rst_n && ins_ok, count_r == cnt_t'($past(count_r) + 1'b1))
  `SPQ_ASSERT_NEXT(a_empty_status, rst_n && in_acc && is_rem && empty, out_status == ST_EMPTY)
  `SPQ_ASSERT_NEXT(a_arr_hold, rst_n && !ins_ok, arr_r == $past(arr_r))

endmodule
`default_nettype wire
